### rtl/core/imhdk_pkg.sv
`timescale 1ns / 1ps

package imhdk_pkg;

  // Heap geometry
  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = 10;
  localparam int POS_W     = 11;
  localparam int VTX_W     = 10;
  localparam int WT_W      = 20;
  localparam int NUM_VTX   = 1024;
  localparam int ENTRY_W   = VTX_W + WT_W;

  // Command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_DEC  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_NOT_LOWER = 3'd4,
    ST_PRESENT   = 3'd5
  } status_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [WT_W-1:0]  weight;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_CHECK,
    S_DECRD,
    S_POPLAST,
    S_UP,
    S_UPCMP,
    S_DN,
    S_DNL,
    S_DNR,
    S_DNCMP,
    S_PLACE,
    S_TOP,
    S_FIN
  } state_t;

endpackage

### rtl/core/imhdk_ram.sv
`timescale 1ns / 1ps

module imhdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/indexed_min_heap_decrease_key.sv
`timescale 1ns / 1ps

// Indexed binary min-heap of (vertex, weight) entries with decrease-key.
// One request at a time: push, pop or decrease, each answered by one result
// with the new top, the entry count and a status. The input stalls until
// the result is loaded. A refused request skips the heap update; a decrease
// that is not lower is refused after its entry is read. A push or decrease
// that goes through climbs level by level, and a pop descends up to 10
// levels. The heap memory has a single read port. After reset all 1024
// entries of the position map are swept clear, during which in_stall is
// high.
module indexed_min_heap_decrease_key
  import imhdk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [VTX_W-1:0]  in_vertex,
  input  logic [WT_W-1:0]   in_weight,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VTX_W-1:0]  out_popped_vertex,
  output logic [WT_W-1:0]   out_popped_weight,
  output logic [VTX_W-1:0]  out_top_vertex,
  output logic [WT_W-1:0]   out_top_weight,
  output logic [POS_W-1:0]  out_entry_count,
  output logic [2:0]        out_status
);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  p_r, p_nxt;
  logic [POS_W:0]    c_r, c_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  entry_t            e_r, e_nxt;
  entry_t            o_r, o_nxt;
  entry_t            pop_r, pop_nxt;
  status_t           st_r, st_nxt;

  logic              out_valid_r, out_valid_nxt;
  entry_t            out_pop_r, out_pop_nxt;
  entry_t            out_top_r, out_top_nxt;
  logic [POS_W-1:0]  out_cnt_r, out_cnt_nxt;
  status_t           out_st_r, out_st_nxt;

  logic              heap_we;
  logic [ADDR_W-1:0] heap_waddr, heap_raddr;
  entry_t            heap_wdata, heap_q;
  logic              pos_we;
  logic [ADDR_W-1:0] pos_waddr, pos_raddr;
  logic [POS_W-1:0]  pos_wdata, pos_q;

  logic [POS_W:0]    left_pos, right_pos, cnt_ext;

  imhdk_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_q)
  );

  imhdk_ram #(.WIDTH(POS_W), .DEPTH(NUM_VTX)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_q)
  );

  assign left_pos  = {p_r, 1'b0};
  assign right_pos = left_pos + 1'b1;
  assign cnt_ext   = {1'b0, cnt_r};

  // Hold state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    c_r       <= c_nxt;
    cmd_r     <= cmd_nxt;
    e_r       <= e_nxt;
    o_r       <= o_nxt;
    pop_r     <= pop_nxt;
    st_r      <= st_nxt;
    out_pop_r <= out_pop_nxt;
    out_top_r <= out_top_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  // Sequence one request through the heap memory
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    c_nxt         = c_r;
    cmd_nxt       = cmd_r;
    e_nxt         = e_r;
    o_nxt         = o_r;
    pop_nxt       = pop_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pop_nxt   = out_pop_r;
    out_top_nxt   = out_top_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    heap_we       = 1'b0;
    heap_waddr    = ADDR_W'(p_r - 1'b1);
    heap_wdata    = e_r;
    heap_raddr    = '0;
    pos_we        = 1'b0;
    pos_waddr     = e_r.vertex;
    pos_wdata     = p_r;
    pos_raddr     = in_vertex;

    unique case (state_r)
      S_CLR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_r;
        pos_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // Root and position lookups start with the accepted request
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          e_nxt     = '{vertex: in_vertex, weight: in_weight};
          pop_nxt   = '0;
          st_nxt    = ST_OK;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        state_nxt = S_TOP;
        case (cmd_r)
          CMD_PUSH: begin
            if (pos_q != '0) begin
              st_nxt = ST_PRESENT;
            end else if (cnt_r == POS_W'(CAPACITY)) begin
              st_nxt = ST_FULL;
            end else begin
              cnt_nxt   = cnt_r + 1'b1;
              p_nxt     = cnt_r + 1'b1;
              state_nxt = S_UP;
            end
          end
          CMD_POP: begin
            if (cnt_r == '0) begin
              st_nxt = ST_EMPTY;
            end else begin
              pop_nxt   = heap_q;
              pos_we    = 1'b1;
              pos_waddr = heap_q.vertex;
              pos_wdata = '0;
              cnt_nxt   = cnt_r - 1'b1;
              if (cnt_r != POS_W'(1)) begin
                heap_raddr = ADDR_W'(cnt_r - 1'b1);
                state_nxt  = S_POPLAST;
              end
            end
          end
          CMD_DEC: begin
            if (pos_q == '0 || pos_q > cnt_r) begin
              st_nxt = ST_ABSENT;
            end else begin
              p_nxt      = pos_q;
              heap_raddr = ADDR_W'(pos_q - 1'b1);
              state_nxt  = S_DECRD;
            end
          end
          default: st_nxt = ST_OK;
        endcase
      end

      S_DECRD: begin
        if (e_r.weight < heap_q.weight) begin
          state_nxt = S_UP;
        end else begin
          st_nxt    = ST_NOT_LOWER;
          state_nxt = S_TOP;
        end
      end

      S_POPLAST: begin
        e_nxt     = heap_q;
        p_nxt     = POS_W'(1);
        state_nxt = S_DN;
      end

      S_UP: begin
        if (p_r == POS_W'(1)) begin
          state_nxt = S_PLACE;
        end else begin
          heap_raddr = ADDR_W'((p_r >> 1) - 1'b1);
          state_nxt  = S_UPCMP;
        end
      end

      S_UPCMP: begin
        // Pull the parent down into the hole while the entry is lighter
        if (e_r.weight < heap_q.weight) begin
          heap_we    = 1'b1;
          heap_wdata = heap_q;
          pos_we     = 1'b1;
          pos_waddr  = heap_q.vertex;
          p_nxt      = p_r >> 1;
          state_nxt  = S_UP;
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_DN: begin
        if (left_pos > cnt_ext) begin
          state_nxt = S_PLACE;
        end else begin
          heap_raddr = ADDR_W'(left_pos - 1'b1);
          state_nxt  = S_DNL;
        end
      end

      S_DNL: begin
        o_nxt = heap_q;
        c_nxt = left_pos;
        if (right_pos <= cnt_ext) begin
          heap_raddr = ADDR_W'(right_pos - 1'b1);
          state_nxt  = S_DNR;
        end else begin
          state_nxt = S_DNCMP;
        end
      end

      S_DNR: begin
        // Take the right child only when strictly lighter
        if (o_r.weight > heap_q.weight) begin
          o_nxt = heap_q;
          c_nxt = right_pos;
        end
        state_nxt = S_DNCMP;
      end

      S_DNCMP: begin
        if (e_r.weight > o_r.weight) begin
          heap_we    = 1'b1;
          heap_wdata = o_r;
          pos_we     = 1'b1;
          pos_waddr  = o_r.vertex;
          p_nxt      = POS_W'(c_r);
          state_nxt  = S_DN;
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        heap_we   = 1'b1;
        pos_we    = 1'b1;
        state_nxt = S_TOP;
      end

      S_TOP: begin
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // Load the result once the output register is free
        heap_raddr = '0;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pop_nxt   = pop_r;
          out_top_nxt   = (cnt_r == '0) ? '0 : heap_q;
          out_cnt_nxt   = cnt_r;
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_popped_vertex = out_pop_r.vertex;
  assign out_popped_weight = out_pop_r.weight;
  assign out_top_vertex    = out_top_r.vertex;
  assign out_top_weight    = out_top_r.weight;
  assign out_entry_count   = out_cnt_r;
  assign out_status        = out_st_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= POS_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_FULL) |-> out_cnt_r == POS_W'(CAPACITY))
    else $error("full status without a full heap");

  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_OK) |-> out_pop_r == '0)
    else $error("popped fields set on a refused request");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cnt_r == '0) |-> out_top_r == '0)
    else $error("top reported on an empty heap");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import imhdk_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [VTX_W-1:0] vertex;
    logic [WT_W-1:0]  weight;
  } request_t;

  typedef struct packed {
    logic [VTX_W-1:0] popped_vertex;
    logic [WT_W-1:0]  popped_weight;
    logic [VTX_W-1:0] top_vertex;
    logic [WT_W-1:0]  top_weight;
    logic [POS_W-1:0] entry_count;
    status_t          status;
  } heap_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_cmd;
  logic [VTX_W-1:0] in_vertex;
  logic [WT_W-1:0]  in_weight;
  logic             out_valid;
  logic             out_stall;
  logic [VTX_W-1:0] out_popped_vertex;
  logic [WT_W-1:0]  out_popped_weight;
  logic [VTX_W-1:0] out_top_vertex;
  logic [WT_W-1:0]  out_top_weight;
  logic [POS_W-1:0] out_entry_count;
  logic [2:0]       out_status;

  indexed_min_heap_decrease_key dut (.*);

  // Shadow heap state
  logic [VTX_W-1:0] shadow_vtx [1:CAPACITY];
  logic [WT_W-1:0]  shadow_wt  [1:CAPACITY];
  int unsigned      shadow_pos [0:NUM_VTX-1];
  int unsigned      shadow_count;

  request_t     pending_requests[$];
  heap_result_t expected_results[$];
  idle_mode_t   idle_mode;
  int           mismatches;
  int           results_seen;
  int           watchdog;
  int           pops_ok, decreases_ok;

  // Clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [VTX_W-1:0] tv;
    logic [WT_W-1:0]  tw;
    tv = shadow_vtx[a];
    tw = shadow_wt[a];
    shadow_vtx[a] = shadow_vtx[b];
    shadow_wt[a] = shadow_wt[b];
    shadow_vtx[b] = tv;
    shadow_wt[b] = tw;
    shadow_pos[shadow_vtx[a]] = a;
    shadow_pos[shadow_vtx[b]] = b;
  endfunction

  function automatic void sift_up(int unsigned p);
    while (p > 1 && shadow_wt[p] < shadow_wt[p / 2]) begin
      swap_slots(p, p / 2);
      p = p / 2;
    end
  endfunction

  function automatic void sift_down(int unsigned p);
    int unsigned l, c;
    forever begin
      l = 2 * p;
      if (l > shadow_count) break;
      c = l;
      if (l + 1 <= shadow_count && shadow_wt[l] > shadow_wt[l + 1]) c = l + 1;
      if (shadow_wt[p] > shadow_wt[c]) begin
        swap_slots(p, c);
        p = c;
      end else begin
        break;
      end
    end
  endfunction

  // Apply one request to the shadow heap and return the expected result
  function automatic heap_result_t apply_request(request_t rq);
    heap_result_t r;
    int unsigned  p;
    r = '0;
    r.status = ST_OK;
    case (rq.cmd)
      CMD_PUSH: begin
        if (shadow_pos[rq.vertex] != 0) begin
          r.status = ST_PRESENT;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_count++;
          shadow_vtx[shadow_count] = rq.vertex;
          shadow_wt[shadow_count] = rq.weight;
          shadow_pos[rq.vertex] = shadow_count;
          sift_up(shadow_count);
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pops_ok++;
          r.popped_vertex = shadow_vtx[1];
          r.popped_weight = shadow_wt[1];
          shadow_pos[shadow_vtx[1]] = 0;
          if (shadow_count > 1) begin
            shadow_vtx[1] = shadow_vtx[shadow_count];
            shadow_wt[1] = shadow_wt[shadow_count];
            shadow_pos[shadow_vtx[1]] = 1;
          end
          shadow_count--;
          sift_down(1);
        end
      end
      CMD_DEC: begin
        p = shadow_pos[rq.vertex];
        if (p == 0 || p > shadow_count) begin
          r.status = ST_ABSENT;
        end else if (!(rq.weight < shadow_wt[p])) begin
          r.status = ST_NOT_LOWER;
        end else begin
          decreases_ok++;
          shadow_wt[p] = rq.weight;
          sift_up(p);
        end
      end
      default: ;
    endcase
    if (shadow_count > 0) begin
      r.top_vertex = shadow_vtx[1];
      r.top_weight = shadow_wt[1];
    end
    r.entry_count = shadow_count[POS_W-1:0];
    return r;
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return chance(79);
      IDLE_BOTH: return chance(29);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return chance(79);
      IDLE_BOTH: return chance(29);
      default:   return 1'b0;
    endcase
  endfunction

  // Mostly pushes, pops and decreases on a small vertex pool so that
  // duplicates, decreases on present vertices and ties happen often
  function automatic request_t random_request();
    request_t rq;
    int       sel;
    sel = $urandom_range(99);
    if (sel < 44) rq.cmd = CMD_PUSH;
    else if (sel < 70) rq.cmd = CMD_POP;
    else if (sel < 95) rq.cmd = CMD_DEC;
    else rq.cmd = CMD_NOP;
    rq.vertex = chance(70) ? VTX_W'($urandom_range(47)) : VTX_W'($urandom);
    rq.weight = chance(40) ? WT_W'($urandom_range(15)) : WT_W'($urandom);
    return rq;
  endfunction

  function automatic request_t mk(logic [1:0] c, int v, int w);
    request_t rq;
    rq.cmd = c;
    rq.vertex = VTX_W'(v);
    rq.weight = WT_W'(w);
    return rq;
  endfunction

  // Driver: hold a stalled request, advance on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(apply_request(mk(in_cmd, in_vertex, in_weight)));
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() > 0 && !sender_idles()) begin
          request_t rq;
          rq = pending_requests.pop_front();
          in_cmd <= rq.cmd;
          in_vertex <= rq.vertex;
          in_weight <= rq.weight;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    out_stall <= rst_n ? receiver_stalls() : 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      heap_result_t act, exp_r;
      act = {out_popped_vertex, out_popped_weight, out_top_vertex, out_top_weight,
             out_entry_count, status_t'(out_status)};
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", act);
      end else begin
        exp_r = expected_results.pop_front();
        if (act !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d: expected pv=%0d pw=%0d tv=%0d tw=%0d n=%0d st=%0d, got pv=%0d pw=%0d tv=%0d tw=%0d n=%0d st=%0d",
                     results_seen, exp_r.popped_vertex, exp_r.popped_weight,
                     exp_r.top_vertex, exp_r.top_weight, exp_r.entry_count,
                     exp_r.status, act.popped_vertex, act.popped_weight,
                     act.top_vertex, act.top_weight, act.entry_count, act.status);
        end
      end
    end
  end

  // Watchdog: count cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      watchdog <= 0;
    end else if (watchdog >= WATCHDOG_LIMIT) begin
      $display("Timeout with %0d results outstanding", expected_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_PUSH;
    in_vertex = '0;
    in_weight = '0;
    out_stall = 1'b0;
    idle_mode = IDLE_NONE;
    mismatches = 0;
    results_seen = 0;
    watchdog = 0;
    pops_ok = 0;
    decreases_ok = 0;
    shadow_count = 0;
    for (int i = 0; i < NUM_VTX; i++) shadow_pos[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, absent decrease, unused code, extremes, ties
    pending_requests.push_back(mk(CMD_POP, 0, 0));
    pending_requests.push_back(mk(CMD_DEC, 7, 1));
    pending_requests.push_back(mk(CMD_NOP, 1023, 'hFFFFF));
    pending_requests.push_back(mk(CMD_PUSH, 1023, 'hFFFFF));
    pending_requests.push_back(mk(CMD_PUSH, 0, 0));
    pending_requests.push_back(mk(CMD_PUSH, 1023, 5));
    pending_requests.push_back(mk(CMD_PUSH, 5, 'hFFFFF));
    pending_requests.push_back(mk(CMD_PUSH, 6, 7));
    pending_requests.push_back(mk(CMD_PUSH, 9, 7));
    pending_requests.push_back(mk(CMD_DEC, 1023, 'hFFFFF));
    pending_requests.push_back(mk(CMD_DEC, 1023, 'hFFFFE));
    pending_requests.push_back(mk(CMD_DEC, 9, 7));
    pending_requests.push_back(mk(CMD_DEC, 5, 3));
    pending_requests.push_back(mk(CMD_NOP, 0, 0));
    for (int i = 0; i < 7; i++) pending_requests.push_back(mk(CMD_POP, 0, 0));
    pending_requests.push_back(mk(CMD_PUSH, 0, 'h55555));
    pending_requests.push_back(mk(CMD_PUSH, 682, 'hAAAAA));
    pending_requests.push_back(mk(CMD_DEC, 682, 0));
    wait_drained();

    // Random phases under each idling pattern
    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_t'(m);
      for (int i = 0; i < 110; i++) pending_requests.push_back(random_request());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d results: %0d successful pops, %0d effective decreases,",
             results_seen, pops_ok, decreases_ok);
    $display("error statuses and four idling patterns; %0d mismatches", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### indexed_min_heap_decrease_key.f
rtl/core/imhdk_pkg.sv
rtl/core/imhdk_ram.sv
rtl/core/indexed_min_heap_decrease_key.sv
verif/tb.sv
